// ===== hdl/lscp_pkg.sv =====
// Shared constants, widths and the controller-to-datapath command struct
// for the line sensor centroid position unit. No dependencies.
`default_nettype none

package lscp_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SAMPLE_W    = 10;
    localparam int WEIGHT_W    = 12;
    localparam int POS_W       = 15;

    localparam int IDX_W   = $clog2(NUM_SENSORS);
    // Sum of inverted samples and the index-weighted moment sum.
    localparam int TOTAL_W = $clog2(((1 << SAMPLE_W) - 1) * NUM_SENSORS + 1);
    localparam int MOM_W   =
        $clog2(((1 << SAMPLE_W) - 1) * NUM_SENSORS * (NUM_SENSORS + 1) / 2 + 1);
    localparam int NUM_W   = WEIGHT_W + MOM_W;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1050);
    localparam logic [POS_W-1:0]    POS_MAX      = {POS_W{1'b1}};

    typedef struct packed {
        logic             store_en;
        logic [IDX_W-1:0] addr;
        logic             frame_end;
        logic             accum_en;
        logic             mult_en;
        logic             div_en;
        logic             out_load;
    } lscp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lscp_datapath.sv =====
// Datapath: sample store, peak tracker, moment accumulators, multiplier
// and restoring divider, plus the result register. Uses lscp_pkg.
`default_nettype none

module lscp_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire lscp_pkg::lscp_cmd_t              cmd,
    input  wire logic                             cfg_we,
    input  wire logic [lscp_pkg::WEIGHT_W-1:0]    cfg_data,
    input  wire logic [lscp_pkg::SAMPLE_W-1:0]    s_sample,
    output logic      [lscp_pkg::POS_W-1:0]       m_position,
    output logic                                  m_no_signal
);
    import lscp_pkg::*;

    logic [SAMPLE_W-1:0] store_reg [NUM_SENSORS];
    logic [SAMPLE_W-1:0] peak_reg, peak_next;
    logic [WEIGHT_W-1:0] weight_step_reg;
    logic [WEIGHT_W-1:0] weight_lat_reg;
    logic [TOTAL_W-1:0]  run_reg, run_next;
    logic [MOM_W-1:0]    mom_reg, mom_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]    pos_reg;
    logic                nosig_reg;

    logic [SAMPLE_W-1:0] inv;
    logic [TOTAL_W:0]    rem_sh;
    logic [TOTAL_W:0]    diff;
    logic                q_bit;
    logic [POS_W-1:0]    pos_calc;

    // Walking from the last sensor down, the running sum of inverted samples
    // is added into the moment once per step, so sensor k counts k+1 times.
    always_comb begin
        inv      = peak_reg - store_reg[cmd.addr];
        run_next = run_reg + TOTAL_W'(inv);
        mom_next = mom_reg + MOM_W'(run_next);
    end

    always_comb begin
        peak_next = peak_reg;
        if (cmd.store_en && (s_sample > peak_reg)) begin
            peak_next = s_sample;
        end
    end

    // One restoring division step per cycle; quotient bits shift into num_reg.
    always_comb begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, run_reg};
        q_bit  = (rem_sh >= {1'b0, run_reg});
        rem_next = q_bit ? diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
        num_next = {num_reg[NUM_W-2:0], q_bit};
    end

    always_comb begin
        if (|num_reg[NUM_W-1:POS_W]) begin
            pos_calc = POS_MAX;
        end else begin
            pos_calc = num_reg[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg        <= '0;
            weight_step_reg <= WEIGHT_RESET;
        end else begin
            if (cfg_we) begin
                weight_step_reg <= cfg_data;
            end
            if (cmd.mult_en) begin
                peak_reg <= '0;
            end else begin
                peak_reg <= peak_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_en) begin
            store_reg[cmd.addr] <= s_sample;
        end
        if (cmd.frame_end) begin
            weight_lat_reg <= weight_step_reg;
            run_reg        <= '0;
            mom_reg        <= '0;
        end else if (cmd.accum_en) begin
            run_reg <= run_next;
            mom_reg <= mom_next;
        end
        if (cmd.mult_en) begin
            num_reg <= NUM_W'(weight_lat_reg) * NUM_W'(mom_reg);
            rem_reg <= '0;
        end else if (cmd.div_en) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load) begin
            if (run_reg == '0) begin
                pos_reg   <= '0;
                nosig_reg <= 1'b1;
            end else begin
                pos_reg   <= pos_calc;
                nosig_reg <= 1'b0;
            end
        end
    end

    assign m_position  = pos_reg;
    assign m_no_signal = nosig_reg;

endmodule

`default_nettype wire

// ===== hdl/lscp_ctrl.sv =====
// Controller: frame sequencing state machine, sample and step counters,
// and the result valid flag. Uses lscp_pkg for widths and the command type.
`default_nettype none

module lscp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lscp_pkg::lscp_cmd_t      cmd
);
    import lscp_pkg::*;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_ACCUM,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                cmd.addr = cnt_reg;
                if (s_valid) begin
                    cmd.store_en = 1'b1;
                    if (cnt_reg == IDX_W'(NUM_SENSORS - 1)) begin
                        cmd.frame_end = 1'b1;
                        cnt_next      = '0;
                        step_next     = STEP_W'(NUM_SENSORS - 1);
                        state_next    = ST_ACCUM;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_ACCUM: begin
                cmd.accum_en = 1'b1;
                cmd.addr     = step_reg[IDX_W-1:0];
                if (step_reg == '0) begin
                    state_next = ST_MULT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_MULT: begin
                cmd.mult_en = 1'b1;
                step_next   = STEP_W'(NUM_W - 1);
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            cnt_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_COLLECT);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/line_sensor_centroid_position_unit.sv =====
// Top level of the line sensor centroid position unit.
// Instantiates lscp_ctrl and lscp_datapath; uses lscp_pkg.
//
// Usage: the sample channel (s_valid, s_ready, s_sample) takes one beat per
// sensor, sensors 0 to NUM_SENSORS-1 in order. After the last beat of a frame
// the unit walks the stored samples once (one sensor per cycle), multiplies
// the moment by weight_step, then runs a restoring divider that produces
// one quotient bit per cycle. The result beat (m_position, m_no_signal) is
// loaded after the last divide step. s_ready is low from the last sample
// beat until the result is loaded; the result register holds its beat while
// m_ready is low, and the next frame's samples are taken meanwhile. A
// finished frame waits for the result register to empty before it is loaded.
// weight_step is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. The value in force at a frame's last sample beat is used.
// Reset (aresetn low, synchronous) clears the frame position, the peak, and
// the result valid flag, and restores weight_step to 1050.
`default_nettype none

module line_sensor_centroid_position_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lscp_pkg::WEIGHT_W-1:0]    cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lscp_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [lscp_pkg::POS_W-1:0]       m_position,
    output logic                                  m_no_signal
);
    import lscp_pkg::*;

    lscp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lscp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lscp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .s_sample    (s_sample),
        .m_position  (m_position),
        .m_no_signal (m_no_signal)
    );

    // A frame's last sample closes the input until the result is loaded.
    a_frame_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.frame_end |=> !s_ready)
        else $error("sample channel open right after frame end");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise m_valid");

    a_no_signal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_signal) |-> (m_position == '0))
        else $error("no_signal result with nonzero position");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && m_valid) |-> m_ready)
        else $error("result overwritten while still waiting");

endmodule

`default_nettype wire
